### src/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg
// Types and constants for the multipart boundary scanner.
// ----------------------------------------------------------------------------
package mbs_pkg;

  localparam int MAX_BOUNDARY_BYTES_DEF = 48;
  localparam int COUNT_BITS_DEF         = 32;

  localparam int NUM_BOUNDARY_WORDS = 6;
  localparam int BOUNDARY_REG_BYTES = NUM_BOUNDARY_WORDS * 8;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int LEN_BITS       = 6;
  localparam int OUT_COUNT_BITS = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WORD0  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WORD5  = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LARGE  = 3'd7;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_BRACE = 8'h7B;

  localparam logic [LEN_BITS-1:0] LENGTH_RESET = 6'd1;
  localparam logic [31:0]         LARGE_RESET  = 32'(4 * 1024 * 1024);

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef enum logic [1:0] {
    CLASS_JSON   = 2'd0,
    CLASS_STRING = 2'd1,
    CLASS_LARGE  = 2'd2,
    CLASS_MEMORY = 2'd3
  } payload_class_t;

  typedef struct packed {
    logic                      scan_status;
    logic [OUT_COUNT_BITS-1:0] data_length;
    logic [OUT_COUNT_BITS-1:0] consumed_count;
    payload_class_t            payload_class;
  } result_t;

endpackage

### src/multipart_boundary_scanner.sv
// ----------------------------------------------------------------------------
// multipart_boundary_scanner
// Scans part content bytes for CR LF "--" boundary and reports the part.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one content byte per item
//   with part_start, part_is_text and buffer_last. Output channel
//   (out_valid / out_stall) carries at most one result per input item:
//   boundary found, or buffer ended before the boundary.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   boundary length, six boundary words and the large-file threshold; it is
//   always ready; the user is to write it only while the scanner is idle,
//   as the block does not enforce this. Throughput: one byte per cycle
//   while in_stall is low. The scan state is updated as a byte is accepted;
//   its result is registered in the output register, which is backed by a
//   one-entry skid register; in_stall is raised only while the skid register
//   holds a result, so the input stalls until the receiver takes the result
//   waiting in the output register. Reset (rst, synchronous) empties both
//   result registers, sets the scanner idle and restores the register
//   defaults. Bytes seen while idle and without part_start produce nothing.
// ----------------------------------------------------------------------------
module multipart_boundary_scanner #(
  parameter int MAX_BOUNDARY_BYTES = mbs_pkg::MAX_BOUNDARY_BYTES_DEF,
  parameter int COUNT_BITS         = mbs_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mbs_pkg::CFG_DATA_BITS-1:0]   cfg_data,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  input  logic                                part_start,
  input  logic                                part_is_text,
  input  logic                                buffer_last,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                scan_status,
  output logic [mbs_pkg::OUT_COUNT_BITS-1:0]  data_length,
  output logic [mbs_pkg::OUT_COUNT_BITS-1:0]  consumed_count,
  output logic [1:0]                          payload_class
);
  import mbs_pkg::*;

  localparam int CMP_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PARSE,
    PH_EXPECT_LF,
    PH_DASH1,
    PH_DASH2,
    PH_BOUNDARY
  } phase_t;

  // configuration
  logic [LEN_BITS-1:0]      boundary_length;
  logic [63:0]              boundary_word [NUM_BOUNDARY_WORDS];
  logic [31:0]              large_threshold;

  // scan state
  phase_t                   scan_phase, scan_phase_next;
  logic [LEN_BITS-1:0]      match_index, match_index_next;
  logic [COUNT_BITS-1:0]    byte_offset, byte_offset_next;
  logic [COUNT_BITS-1:0]    last_cr_offset, last_cr_offset_next;
  logic                     first_byte_brace, first_byte_brace_next;
  logic                     text_part, text_part_next;

  // result registers
  result_t                  out_res, skid_res, res_next;
  logic                     skid_valid;

  logic                     accept;
  logic                     produce;
  logic                     done;
  logic [7:0]               bnd_bytes [BOUNDARY_REG_BYTES];
  logic [7:0]               expect_byte;
  logic [LEN_BITS-1:0]      eff_length;
  logic [LEN_BITS-1:0]      mi_inc;
  phase_t                   ph0;
  logic [LEN_BITS-1:0]      mi0;
  logic [COUNT_BITS-1:0]    off0, cr0;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_length <= LENGTH_RESET;
      for (int i = 0; i < NUM_BOUNDARY_WORDS; i++) begin
        boundary_word[i] <= '0;
      end
      large_threshold <= LARGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LENGTH) begin
        boundary_length <= cfg_data[LEN_BITS-1:0];
      end else if (cfg_index == REG_LARGE) begin
        large_threshold <= cfg_data[31:0];
      end else if (cfg_index >= REG_WORD0 && cfg_index <= REG_WORD5) begin
        boundary_word[3'(cfg_index - REG_WORD0)] <= cfg_data;
      end
    end
  end

  for (genvar g = 0; g < BOUNDARY_REG_BYTES; g++) begin : g_bytes
    assign bnd_bytes[g] = boundary_word[g / 8][(g % 8) * 8 +: 8];
  end

  assign eff_length = ({1'b0, boundary_length} > 7'(MAX_BOUNDARY_BYTES))
                    ? LEN_BITS'(MAX_BOUNDARY_BYTES) : boundary_length;

  // start of part discards any scan in progress
  assign ph0  = part_start ? PH_PARSE : scan_phase;
  assign mi0  = part_start ? '0 : match_index;
  assign off0 = part_start ? '0 : byte_offset;
  assign cr0  = part_start ? '0 : last_cr_offset;

  assign expect_byte = ({1'b0, mi0} < 7'(BOUNDARY_REG_BYTES)) ? bnd_bytes[mi0] : 8'h00;
  assign mi_inc      = mi0 + LEN_BITS'(1);

  always_comb begin
    scan_phase_next       = ph0;
    match_index_next      = mi0;
    byte_offset_next      = off0;
    last_cr_offset_next   = cr0;
    first_byte_brace_next = part_start ? (data_byte == CH_BRACE) : first_byte_brace;
    text_part_next        = part_start ? part_is_text : text_part;
    done                  = 1'b0;
    produce               = 1'b0;
    res_next              = '0;

    if (ph0 != PH_IDLE) begin
      if (data_byte == CH_CR) begin
        scan_phase_next     = PH_EXPECT_LF;
        last_cr_offset_next = off0;
      end else if (data_byte == CH_LF) begin
        scan_phase_next = (ph0 == PH_EXPECT_LF) ? PH_DASH1 : PH_PARSE;
      end else begin
        case (ph0)
          PH_DASH1: begin
            scan_phase_next = (data_byte == CH_DASH) ? PH_DASH2 : PH_PARSE;
          end
          PH_DASH2: begin
            if (data_byte == CH_DASH) begin
              match_index_next = '0;
              if (eff_length == '0) begin
                done = 1'b1;
              end else begin
                scan_phase_next = PH_BOUNDARY;
              end
            end else begin
              scan_phase_next = PH_PARSE;
            end
          end
          PH_BOUNDARY: begin
            if ({1'b0, mi0} < 7'(MAX_BOUNDARY_BYTES) && data_byte == expect_byte) begin
              match_index_next = mi_inc;
              if (mi_inc >= eff_length) begin
                done = 1'b1;
              end
            end else begin
              scan_phase_next = PH_PARSE;
            end
          end
          default: begin
            scan_phase_next = PH_PARSE;
          end
        endcase
      end

      byte_offset_next        = off0 + COUNT_BITS'(1);
      res_next.consumed_count = OUT_COUNT_BITS'(byte_offset_next);

      if (done) begin
        produce               = 1'b1;
        res_next.scan_status  = STATUS_FOUND;
        res_next.data_length  = OUT_COUNT_BITS'(last_cr_offset_next);
        if (text_part_next) begin
          res_next.payload_class = first_byte_brace_next ? CLASS_JSON : CLASS_STRING;
        end else begin
          res_next.payload_class =
            (CMP_BITS'(last_cr_offset_next) > CMP_BITS'(large_threshold))
            ? CLASS_LARGE : CLASS_MEMORY;
        end
        scan_phase_next  = PH_IDLE;
        match_index_next = '0;
      end else if (buffer_last) begin
        produce                = 1'b1;
        res_next.scan_status   = STATUS_ERROR;
        res_next.data_length   = '0;
        res_next.payload_class = CLASS_JSON;
        scan_phase_next        = PH_IDLE;
        match_index_next       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase       <= PH_IDLE;
      match_index      <= '0;
      byte_offset      <= '0;
      last_cr_offset   <= '0;
      first_byte_brace <= 1'b0;
      text_part        <= 1'b0;
      out_valid        <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (accept) begin
        scan_phase       <= scan_phase_next;
        match_index      <= match_index_next;
        byte_offset      <= byte_offset_next;
        last_cr_offset   <= last_cr_offset_next;
        first_byte_brace <= first_byte_brace_next;
        text_part        <= text_part_next;
      end
      if (out_valid && out_stall) begin
        if (accept && produce) begin
          skid_valid <= 1'b1;
          skid_res   <= res_next;
        end
      end else if (skid_valid) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && produce;
        out_res   <= res_next;
      end
    end
  end

  assign scan_status    = out_res.scan_status;
  assign data_length    = out_res.data_length;
  assign consumed_count = out_res.consumed_count;
  assign payload_class  = out_res.payload_class;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.scan_status == STATUS_ERROR) |->
      (out_res.data_length == '0 && out_res.payload_class == CLASS_JSON))
    else $error("error result carries length or class");

  a_idle_clears_match: assert property (@(posedge clk) disable iff (rst)
    (scan_phase == PH_IDLE) |-> (match_index == '0))
    else $error("match index set while idle");

  a_result_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && produce) |=> (scan_phase == PH_IDLE && match_index == '0))
    else $error("scanner not idle after a result");

endmodule
